/* rtl/core/mfom_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the mecanum mixer.
`default_nettype none

package mfom_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEAD_ZONE       = 3'd0,
        CFG_MAX_OUTPUT      = 3'd1,
        CFG_INVERT_ENABLE   = 3'd2,
        CFG_RELATIVE_ENABLE = 3'd3,
        CFG_ORIGIN_HEADING  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [6:0]  dead_zone;
        logic [6:0]  max_output;
        logic        invert_enable;
        logic        relative_enable;
        logic [15:0] origin_heading;
    } cfg_t;

    // CORDIC datapath
    localparam int unsigned XY_SHIFT  = 16;
    localparam int unsigned XY_W      = 27;
    localparam int unsigned Z_W       = 32;
    localparam int unsigned ATAN_LEN  = 24;
    localparam int unsigned KINV_FRAC = 30;
    localparam int unsigned KINV_W    = 31;
    localparam logic signed [KINV_W-1:0] KINV_Q30 = 31'sd652032874;

    // Stick values after dead zone and invert: forward/strafe reach +128
    typedef struct packed {
        logic signed [8:0] f;
        logic signed [8:0] s;
        logic signed [7:0] t;
    } axes_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        axes_t                  ax;
    } cordic_beat_t;

    // atan(2^-i) in binary angle units (2^32 per turn), rounded to nearest
    function automatic logic [Z_W-1:0] atan_entry(input int unsigned idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mfom_cmd_if.sv */
// Command channel: three stick axes and the measured heading.
`default_nettype none

interface mfom_cmd_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] forward_cmd;
    logic signed [7:0] strafe_cmd;
    logic signed [7:0] turn_cmd;
    logic [15:0]       current_heading;

    modport source (
        output valid, forward_cmd, strafe_cmd, turn_cmd, current_heading,
        input  ready
    );
    modport sink (
        input  valid, forward_cmd, strafe_cmd, turn_cmd, current_heading,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/mfom_speed_if.sv */
// Speed channel: four wheel speeds in fixed point percent.
`default_nettype none

interface mfom_speed_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_left_speed;
    logic signed [15:0] back_left_speed;
    logic signed [15:0] front_right_speed;
    logic signed [15:0] back_right_speed;

    modport source (
        output valid, front_left_speed, back_left_speed, front_right_speed,
               back_right_speed,
        input  ready
    );
    modport sink (
        input  valid, front_left_speed, back_left_speed, front_right_speed,
               back_right_speed,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/mfom_prep.sv */
// Front end: dead zone, invert, heading difference and binary angle, quadrant fold.
`default_nettype none

module mfom_prep
    import mfom_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    mfom_cmd_if.sink    cmd,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output cordic_beat_t dn_beat
);

    localparam int unsigned NSTAGE = 6;

    // a = floor((d * 2^32 + 18000) / 36000) = 119304*d + floor((728*d + 562) / 1125)
    localparam logic [15:0] TURN_CENTI = 16'd36000;
    localparam logic [31:0] ANG_WHOLE  = 32'd119304;
    localparam logic [24:0] ANG_REM    = 25'd728;
    localparam logic [24:0] ANG_BIAS   = 25'd562;
    localparam logic [24:0] DIV_DEN    = 25'd1125;
    localparam int unsigned RECIP_SH   = 25;
    localparam logic [39:0] RECIP      = 40'd29826;   // floor(2^25 / 1125)

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] rdy;
    logic [NSTAGE-1:0] vld_in;
    logic [NSTAGE-1:0] load;

    axes_t        ax0_reg, ax1_reg, ax2_reg, ax3_reg, ax4_reg;
    axes_t        ax0_next;
    logic [15:0]  c0_reg, c0_next;
    logic [15:0]  d1_reg, d1_next;
    logic [31:0]  p2_reg, p2_next, p3_reg, p4_reg;
    logic [24:0]  n2_reg, n2_next, n3_reg;
    logic [14:0]  qe3_reg, qe3_next;
    logic [14:0]  q4_reg, q4_next;
    cordic_beat_t beat5_reg, beat5_next;

    logic [15:0]  orig_mod;
    logic [39:0]  qprod;
    logic [24:0]  rem4;
    logic [31:0]  ang;
    logic         fold;
    logic signed [XY_W-1:0] xe, ye;

    function automatic logic signed [7:0] dead(input logic signed [7:0] v,
                                               input logic [6:0] dz);
        logic [7:0] mag;
        mag = v[7] ? (~v + 8'd1) : v;
        return (mag < {1'b0, dz}) ? 8'sd0 : v;
    endfunction

    assign vld_in = {vld_reg[NSTAGE-2:0], cmd.valid};
    assign rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || dn_ready;
    for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign load = rdy & vld_in;

    assign cmd.ready = rdy[0];
    assign dn_valid  = vld_reg[NSTAGE-1];
    assign dn_beat   = beat5_reg;

    always_comb
    begin
        ax0_next.f = 9'(dead(cmd.forward_cmd, cfg.dead_zone));
        ax0_next.s = 9'(dead(cmd.strafe_cmd, cfg.dead_zone));
        ax0_next.t = dead(cmd.turn_cmd, cfg.dead_zone);
        if (cfg.invert_enable)
        begin
            ax0_next.f = -ax0_next.f;
            ax0_next.s = -ax0_next.s;
        end
        c0_next = (cmd.current_heading >= TURN_CENTI) ?
                  cmd.current_heading - TURN_CENTI : cmd.current_heading;

        orig_mod = (cfg.origin_heading >= TURN_CENTI) ?
                   cfg.origin_heading - TURN_CENTI : cfg.origin_heading;
        d1_next = (orig_mod >= c0_reg) ? orig_mod - c0_reg :
                  16'(17'(orig_mod) + 17'(TURN_CENTI) - 17'(c0_reg));

        p2_next = 32'(d1_reg) * ANG_WHOLE;
        n2_next = 25'(d1_reg) * ANG_REM + ANG_BIAS;

        qprod    = 40'(n2_reg) * RECIP;
        qe3_next = qprod[RECIP_SH +: 15];

        // estimate is low by at most one
        rem4    = n3_reg - 25'(qe3_reg) * DIV_DEN;
        q4_next = qe3_reg + 15'(rem4 >= DIV_DEN);

        // fold angles beyond a quarter turn: negate vector, add half a turn
        ang  = p4_reg + 32'(q4_reg);
        fold = ang[31] ^ ang[30];
        xe   = XY_W'(ax4_reg.f) <<< XY_SHIFT;
        ye   = XY_W'(ax4_reg.s) <<< XY_SHIFT;
        beat5_next.x  = fold ? -xe : xe;
        beat5_next.y  = fold ? -ye : ye;
        beat5_next.z  = {ang[31] ^ fold, ang[30:0]};
        beat5_next.ax = ax4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            ax0_reg <= ax0_next;
            c0_reg  <= c0_next;
        end
        if (load[1])
        begin
            ax1_reg <= ax0_reg;
            d1_reg  <= d1_next;
        end
        if (load[2])
        begin
            ax2_reg <= ax1_reg;
            p2_reg  <= p2_next;
            n2_reg  <= n2_next;
        end
        if (load[3])
        begin
            ax3_reg <= ax2_reg;
            p3_reg  <= p2_reg;
            n3_reg  <= n2_reg;
            qe3_reg <= qe3_next;
        end
        if (load[4])
        begin
            ax4_reg <= ax3_reg;
            p4_reg  <= p3_reg;
            q4_reg  <= q4_next;
        end
        if (load[5])
        begin
            beat5_reg <= beat5_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mfom_cell.sv */
// One CORDIC micro-rotation cell of the rotation chain.
`default_nettype none

module mfom_cell
    import mfom_pkg::*;
#(
    parameter int unsigned STAGE = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire cordic_beat_t up_beat,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output cordic_beat_t dn_beat
);

    localparam logic signed [Z_W-1:0] ATAN = atan_entry(STAGE);

    logic         vld_reg;
    cordic_beat_t beat_reg, beat_next;
    logic signed [XY_W-1:0] xs, ys;

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_beat  = beat_reg;

    always_comb
    begin
        xs = up_beat.x >>> STAGE;
        ys = up_beat.y >>> STAGE;
        beat_next = up_beat;
        if (!up_beat.z[Z_W-1])
        begin
            beat_next.x = up_beat.x - ys;
            beat_next.y = up_beat.y + xs;
            beat_next.z = up_beat.z - ATAN;
        end
        else
        begin
            beat_next.x = up_beat.x + ys;
            beat_next.y = up_beat.y - xs;
            beat_next.z = up_beat.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mfom_post.sv */
// Back end: gain compensation and rounding to fixed point (relative mode), wheel mixing and clamp.
`default_nettype none

module mfom_post
    import mfom_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    up_valid,
    output logic         up_ready,
    input  wire cordic_beat_t up_beat,
    mfom_speed_if.source speed
);

    localparam int unsigned NSTAGE = 3;
    localparam int unsigned PROD_W = XY_W + KINV_W;
    localparam int unsigned SH     = XY_SHIFT + KINV_FRAC - FRAC_BITS;
    localparam int unsigned FQ_W   = FRAC_BITS + 11;
    localparam int unsigned SUM_W  = FQ_W + 2;
    localparam logic signed [PROD_W-1:0] RND    = PROD_W'(1) << (SH - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0]  SAT_LO = -SUM_W'(32768);

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] rdy;
    logic [NSTAGE-1:0] vld_in;
    logic [NSTAGE-1:0] load;

    logic signed [PROD_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic signed [PROD_W-1:0] rx, ry;
    axes_t                    ax0_reg;
    logic signed [FQ_W-1:0]   fq_reg, fq_next, sq_reg, sq_next, tq_reg, tq_next;
    logic signed [SUM_W-1:0]  fe, se, te, lim;
    logic signed [15:0] fl_reg, fl_next, bl_reg, bl_next;
    logic signed [15:0] fr_reg, fr_next, br_reg, br_next;

    function automatic logic signed [15:0] finish(input logic signed [SUM_W-1:0] v,
                                                  input logic signed [SUM_W-1:0] lm);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > lm)
            c = lm;
        if (c < -lm)
            c = -lm;
        if (c > SAT_HI)
            c = SAT_HI;
        if (c < SAT_LO)
            c = SAT_LO;
        return c[15:0];
    endfunction

    assign vld_in = {vld_reg[NSTAGE-2:0], up_valid};
    assign rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || speed.ready;
    for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign load = rdy & vld_in;

    assign up_ready                = rdy[0];
    assign speed.valid             = vld_reg[NSTAGE-1];
    assign speed.front_left_speed  = fl_reg;
    assign speed.back_left_speed   = bl_reg;
    assign speed.front_right_speed = fr_reg;
    assign speed.back_right_speed  = br_reg;

    always_comb
    begin
        mx_next = PROD_W'(up_beat.x) * PROD_W'(KINV_Q30);
        my_next = PROD_W'(up_beat.y) * PROD_W'(KINV_Q30);

        // round half up to FRAC_BITS fractional bits
        rx = mx_reg + RND;
        ry = my_reg + RND;
        if (cfg.relative_enable)
        begin
            fq_next = rx[SH +: FQ_W];
            sq_next = ry[SH +: FQ_W];
        end
        else
        begin
            fq_next = FQ_W'(ax0_reg.f) <<< FRAC_BITS;
            sq_next = FQ_W'(ax0_reg.s) <<< FRAC_BITS;
        end
        // turn is halved
        tq_next = FQ_W'(ax0_reg.t) <<< (FRAC_BITS - 1);

        fe  = SUM_W'(fq_reg);
        se  = SUM_W'(sq_reg);
        te  = SUM_W'(tq_reg);
        lim = SUM_W'({1'b0, cfg.max_output}) << FRAC_BITS;
        fl_next = finish(fe + se + te, lim);
        bl_next = finish(fe - se + te, lim);
        fr_next = finish(fe - se - te, lim);
        br_next = finish(fe + se - te, lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            ax0_reg <= up_beat.ax;
        end
        if (load[1])
        begin
            fq_reg <= fq_next;
            sq_reg <= sq_next;
            tq_reg <= tq_next;
        end
        if (load[2])
        begin
            fl_reg <= fl_next;
            bl_reg <= bl_next;
            fr_reg <= fr_next;
            br_reg <= br_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mecanum_field_oriented_mixer.sv */
// From command beat to speed beat: 6 front-end stages, one per CORDIC
// cell, 3 back-end stages. Throughput: one beat per cycle while the
// speed channel is ready; every stage is a register with its own
// valid, so a stalled speed beat holds only the stages that are full.
// Reset clears all valid flags and loads the configuration defaults.
`default_nettype none

module mecanum_field_oriented_mixer
    import mfom_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = 16,
    parameter int unsigned FRAC_BITS     = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mfom_cmd_if.sink                    cmd,
    mfom_speed_if.source                speed,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    cordic_beat_t             chain_beat  [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]   chain_valid;
    logic [CORDIC_STAGES:0]   chain_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone       <= 7'd5;
            cfg_reg.max_output      <= 7'd100;
            cfg_reg.invert_enable   <= 1'b0;
            cfg_reg.relative_enable <= 1'b0;
            cfg_reg.origin_heading  <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE:       cfg_reg.dead_zone       <= cfg_data[6:0];
                CFG_MAX_OUTPUT:      cfg_reg.max_output      <= cfg_data[6:0];
                CFG_INVERT_ENABLE:   cfg_reg.invert_enable   <= cfg_data[0];
                CFG_RELATIVE_ENABLE: cfg_reg.relative_enable <= cfg_data[0];
                CFG_ORIGIN_HEADING:  cfg_reg.origin_heading  <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    mfom_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_beat  (chain_beat[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        mfom_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_beat  (chain_beat[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_beat  (chain_beat[i+1])
        );
    end

    mfom_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (chain_valid[CORDIC_STAGES]),
        .up_ready (chain_ready[CORDIC_STAGES]),
        .up_beat  (chain_beat[CORDIC_STAGES]),
        .speed    (speed)
    );

endmodule

`default_nettype wire
